// ----- design/kbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbe_pkg
// Shared types, codes and helpers of the kinked bend energy pipeline.
// ----------------------------------------------------------------------------
package kbe_pkg;

   localparam int CSR_AW   = 6;
   localparam int IN_W     = 96;
   localparam int OUT_W    = 200;

   // register indexes, byte address 8*i
   localparam logic [2:0] REG_ROT    = 3'd0;
   localparam logic [2:0] REG_TWIST  = 3'd1;
   localparam logic [2:0] REG_XFLAGS = 3'd2;
   localparam logic [2:0] REG_LCURVE = 3'd3;
   localparam logic [2:0] REG_LEDGE  = 3'd4;
   localparam logic [2:0] REG_RCURVE = 3'd5;
   localparam logic [2:0] REG_REDGE  = 3'd6;

   localparam logic [63:0] ROT_RESET = 64'h4000_0000_0000_0000;

   // kink state codes
   localparam logic [1:0] KINK_NONE  = 2'd0;
   localparam logic [1:0] KINK_LEFT  = 2'd1;
   localparam logic [1:0] KINK_RIGHT = 2'd2;

   typedef struct packed {
      logic signed [31:0] cos_v;
      logic signed [31:0] sin_v;
      logic [31:0]        k1;
      logic [31:0]        ky;
      logic [31:0]        kx;
      logic               lact;
      logic               ract;
      logic [31:0]        kl;
      logic signed [31:0] xl;
      logic signed [31:0] hl;
      logic signed [31:0] xcl;
      logic [31:0]        kr;
      logic signed [31:0] xr;
      logic signed [31:0] hr;
      logic signed [31:0] xcr;
   } cfg_type;

   // output of the front end (rotation and branch decode)
   typedef struct packed {
      logic [35:0]        m0;
      logic [35:0]        my;
      logic [35:0]        mx;
      logic [31:0]        kxsel;
      logic signed [31:0] off;
      logic [1:0]         ks;
      logic               lmove;
      logic               rmove;
      logic signed [35:0] xnl;
      logic signed [35:0] xnr;
      logic signed [34:0] y;
      logic [31:0]        t1;
      logic [31:0]        t2;
   } front_type;

   // fields that ride alongside the quadratic units
   typedef struct packed {
      logic signed [31:0] off;
      logic [1:0]         ks;
      logic               lmove;
      logic               rmove;
      logic [31:0]        t1;
      logic [31:0]        t2;
   } side_type;

   typedef struct packed {
      logic [31:0] l1;
      logic [31:0] l2;
      logic [31:0] r1;
      logic [31:0] r2;
   } swap_type;

   function automatic logic [35:0] mag36(input logic [35:0] v);
      return v[35] ? (~v + 36'd1) : v;
   endfunction

   function automatic logic [31:0] sat32(input logic [38:0] v);
      logic [31:0] r;
      if (!v[38] && (|v[37:31])) begin
         r = 32'h7FFF_FFFF;
      end else if (v[38] && !(&v[37:31])) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- design/kbe_quad.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbe_quad
// Four-stage unit: q = floor(k * m^2 / 2^40) mod 2^64, m Q.28, k Q16.16.
// ----------------------------------------------------------------------------
module kbe_quad (
   input  logic        clock,
   input  logic        adv,
   input  logic [35:0] m,
   input  logic [31:0] k,
   output logic [63:0] q
);
   import kbe_pkg::*;

   logic [35:0]  phh_ff, phl_ff, pll_ff;
   logic [35:0]  phh_in, phl_in, pll_in;
   logic [31:0]  k1_ff, k2_ff;
   logic [71:0]  sq_ff, sq_in;
   logic [55:0]  r0_ff, r1_ff, r2_ff;
   logic [55:0]  r0_in, r1_in, r2_in;
   logic [103:0] full_in;
   logic [63:0]  q_ff;

   // m split into two 18-bit halves
   assign phh_in = 36'(m[35:18]) * 36'(m[35:18]);
   assign phl_in = 36'(m[35:18]) * 36'(m[17:0]);
   assign pll_in = 36'(m[17:0]) * 36'(m[17:0]);

   assign sq_in = {phh_ff, 36'd0} + {17'd0, phl_ff, 19'd0} + {36'd0, pll_ff};

   // k times square in three 24-bit slices
   assign r0_in = 56'(sq_ff[23:0]) * 56'(k2_ff);
   assign r1_in = 56'(sq_ff[47:24]) * 56'(k2_ff);
   assign r2_in = 56'(sq_ff[71:48]) * 56'(k2_ff);

   assign full_in = {r2_ff, 48'd0} + {24'd0, r1_ff, 24'd0} + {48'd0, r0_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         phh_ff <= phh_in;
         phl_ff <= phl_in;
         pll_ff <= pll_in;
         k1_ff  <= k;
         sq_ff  <= sq_in;
         k2_ff  <= k1_ff;
         r0_ff  <= r0_in;
         r1_ff  <= r1_in;
         r2_ff  <= r2_in;
         q_ff   <= full_in[103:40];
      end
   end

   assign q = q_ff;

endmodule

// ----- design/kbe_swap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbe_swap
// Two-stage back rotation of a swapped x and y into a pair of angles.
// ----------------------------------------------------------------------------
module kbe_swap (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [35:0] xn,
   input  logic signed [34:0] y,
   input  logic signed [31:0] cos_v,
   input  logic signed [31:0] sin_v,
   output logic [31:0]        new_one,
   output logic [31:0]        new_two
);
   import kbe_pkg::*;

   logic signed [67:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [67:0] pa_in, pb_in, pc_in, pd_in;
   logic signed [68:0] sum1, sum2;
   logic [31:0]        n1_ff, n2_ff;
   logic [31:0]        n1_in, n2_in;

   assign pa_in = 68'(cos_v) * 68'(xn);
   assign pb_in = 68'(sin_v) * 68'(y);
   assign pc_in = 68'(sin_v) * 68'(xn);
   assign pd_in = 68'(cos_v) * 68'(y);

   // c*xn + s*y and c*y - s*xn, floor by 2^30
   assign sum1  = {pa_ff[67], pa_ff} + {pb_ff[67], pb_ff};
   assign sum2  = {pd_ff[67], pd_ff} - {pc_ff[67], pc_ff};
   assign n1_in = sat32(sum1[68:30]);
   assign n2_in = sat32(sum2[68:30]);

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         pc_ff <= pc_in;
         pd_ff <= pd_in;
         n1_ff <= n1_in;
         n2_ff <= n2_in;
      end
   end

   assign new_one = n1_ff;
   assign new_two = n2_ff;

endmodule

// ----- design/kbe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbe_front
// Three-stage front end: kink rotation into x and y, branch and swap decode.
// ----------------------------------------------------------------------------
module kbe_front (
   input  logic                clock,
   input  logic                adv,
   input  logic [31:0]         t0,
   input  logic [31:0]         t1,
   input  logic [31:0]         t2,
   input  kbe_pkg::cfg_type    cfg,
   output kbe_pkg::front_type  fr
);
   import kbe_pkg::*;

   // stage 1: products
   logic signed [63:0] ct1_ff, st2_ff, st1_ff, ct2_ff;
   logic signed [63:0] ct1_in, st2_in, st1_in, ct2_in;
   logic [31:0]        t0a_ff, t1a_ff, t2a_ff;
   // stage 2: x, y
   logic signed [64:0] xsum, ysum;
   logic signed [34:0] x_ff, y_ff;
   logic [35:0]        m0_ff, m0_in;
   logic [31:0]        t1b_ff, t2b_ff;
   // stage 3: decode
   logic signed [35:0] xe, ye, dxl, dxr, dx;
   logic signed [35:0] xle, xre, xcle, xcre;
   logic               inl, inr;
   front_type          fr_ff, fr_in;

   assign ct1_in = 64'(cfg.cos_v) * 64'($signed(t1));
   assign st2_in = 64'(cfg.sin_v) * 64'($signed(t2));
   assign st1_in = 64'(cfg.sin_v) * 64'($signed(t1));
   assign ct2_in = 64'(cfg.cos_v) * 64'($signed(t2));

   assign xsum  = {ct1_ff[63], ct1_ff} - {st2_ff[63], st2_ff};
   assign ysum  = {st1_ff[63], st1_ff} + {ct2_ff[63], ct2_ff};
   assign m0_in = mag36({{4{t0a_ff[31]}}, t0a_ff});

   assign xe   = {x_ff[34], x_ff};
   assign ye   = {y_ff[34], y_ff};
   assign xle  = {{4{cfg.xl[31]}}, cfg.xl};
   assign xre  = {{4{cfg.xr[31]}}, cfg.xr};
   assign xcle = {{4{cfg.xcl[31]}}, cfg.xcl};
   assign xcre = {{4{cfg.xcr[31]}}, cfg.xcr};
   assign inl  = cfg.lact && (xe < xcle);
   assign inr  = cfg.ract && (xe > xcre);
   assign dxl  = xe - xle;
   assign dxr  = xe - xre;

   always_comb begin
      dx          = inl ? dxl : (inr ? dxr : xe);
      fr_in.m0    = m0_ff;
      fr_in.my    = mag36(ye);
      fr_in.mx    = mag36(dx);
      fr_in.kxsel = inl ? cfg.kl : (inr ? cfg.kr : cfg.kx);
      fr_in.off   = inl ? cfg.hl : (inr ? cfg.hr : 32'sd0);
      // both regions at once: energy goes left, state reads right
      fr_in.ks    = inr ? KINK_RIGHT : (inl ? KINK_LEFT : KINK_NONE);
      fr_in.lmove = cfg.lact && !inr;
      fr_in.rmove = cfg.ract && !inl;
      fr_in.xnl   = inl ? (xe - xcle) : (xe + xcle);
      fr_in.xnr   = inr ? (xe - xcre) : (xe + xcre);
      fr_in.y     = y_ff;
      fr_in.t1    = t1b_ff;
      fr_in.t2    = t2b_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ct1_ff <= ct1_in;
         st2_ff <= st2_in;
         st1_ff <= st1_in;
         ct2_ff <= ct2_in;
         t0a_ff <= t0;
         t1a_ff <= t1;
         t2a_ff <= t2;
         x_ff   <= xsum[64:30];
         y_ff   <= ysum[64:30];
         m0_ff  <= m0_in;
         t1b_ff <= t1a_ff;
         t2b_ff <= t2a_ff;
         fr_ff  <= fr_in;
      end
   end

   assign fr = fr_ff;

endmodule

// ----- design/kinked_bend_energy.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kinked_bend_energy
// Streaming kinked bend energy and kink swap evaluator.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one item per handshake: three Q4.28 bend angles.
//  rsp_* returns one result item per input item, in order: Q32.32 energy,
//  kink state, and the left and right swap proposals with moved flags.
//  csr_* is a write/read register port; registers sit at byte address 8*i.
//  Users must have them written only while no item is in flight (unchecked).
// Throughput: one item per clock unless stalled; fully pipelined datapath.
// Pipeline: an item passes 3 front-end stages for the rotation and branch
//  decode, 4 stages in the squaring units and 1 output register on its way
//  from accept to rsp_tvalid, after any wait in the input skid.
// Reset: clears the pipeline valid bits, the skid flag and the output valid,
//  and loads the registers with cosine 1.0 and all else zero.
// Stall: while rsp_tvalid is high and rsp_tready low, the whole pipeline
//  holds; one more item is still taken into a skid register before
//  req_tready drops.
// ----------------------------------------------------------------------------
module kinked_bend_energy (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // angle_zero[31:0], angle_one[63:32], angle_two[95:64]
   input  logic [kbe_pkg::IN_W-1:0]      req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // energy[63:0], kink_state[65:64], left_moved[66], left_new_one[98:67],
   // left_new_two[130:99], right_moved[131], right_new_one[163:132],
   // right_new_two[195:164], zero fill[199:196]
   output logic [kbe_pkg::OUT_W-1:0]     rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [kbe_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [63:0]                   csr_pwdata,
   output logic [63:0]                   csr_prdata,
   output logic                          csr_pready
);
   import kbe_pkg::*;

   // configuration registers
   logic [63:0] rot_ff, twist_ff, lcurve_ff, ledge_ff, rcurve_ff, redge_ff;
   logic [63:0] rot_in, twist_in, lcurve_in, ledge_in, rcurve_in, redge_in;
   logic [33:0] xflags_ff, xflags_in;
   logic        wr;
   logic [2:0]  idx;
   cfg_type     cfg;

   // handshake and pipeline control
   logic              adv, fire_in;
   logic              skid_full_ff, skid_full_in;
   logic [IN_W-1:0]   skid_data_ff, skid_data_in;
   logic [IN_W-1:0]   s_data;
   logic              vld_ff [0:6];
   logic              vld_in [0:6];
   logic              out_vld_ff, out_vld_in;
   logic [OUT_W-1:0]  out_data_ff, out_data_in;

   // datapath
   front_type   fr;
   side_type    side_ff [0:3];
   swap_type    swp_ff [0:1];
   swap_type    swp_w;
   logic [63:0] q0, qy, qx, offs, e_in;
   logic [31:0] ln1, ln2, rn1, rn2;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx = csr_paddr[CSR_AW-1:3];

   always_comb begin
      rot_in    = rot_ff;
      twist_in  = twist_ff;
      xflags_in = xflags_ff;
      lcurve_in = lcurve_ff;
      ledge_in  = ledge_ff;
      rcurve_in = rcurve_ff;
      redge_in  = redge_ff;
      if (wr) begin
         case (idx)
            REG_ROT:    rot_in    = csr_pwdata;
            REG_TWIST:  twist_in  = csr_pwdata;
            REG_XFLAGS: xflags_in = csr_pwdata[33:0];
            REG_LCURVE: lcurve_in = csr_pwdata;
            REG_LEDGE:  ledge_in  = csr_pwdata;
            REG_RCURVE: rcurve_in = csr_pwdata;
            REG_REDGE:  redge_in  = csr_pwdata;
            default:    rot_in    = rot_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ROT:    csr_prdata = rot_ff;
         REG_TWIST:  csr_prdata = twist_ff;
         REG_XFLAGS: csr_prdata = {30'd0, xflags_ff};
         REG_LCURVE: csr_prdata = lcurve_ff;
         REG_LEDGE:  csr_prdata = ledge_ff;
         REG_RCURVE: csr_prdata = rcurve_ff;
         REG_REDGE:  csr_prdata = redge_ff;
         default:    csr_prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff    <= ROT_RESET;
         twist_ff  <= 64'd0;
         xflags_ff <= 34'd0;
         lcurve_ff <= 64'd0;
         ledge_ff  <= 64'd0;
         rcurve_ff <= 64'd0;
         redge_ff  <= 64'd0;
      end else begin
         rot_ff    <= rot_in;
         twist_ff  <= twist_in;
         xflags_ff <= xflags_in;
         lcurve_ff <= lcurve_in;
         ledge_ff  <= ledge_in;
         rcurve_ff <= rcurve_in;
         redge_ff  <= redge_in;
      end
   end

   always_comb begin
      cfg.cos_v = $signed(rot_ff[63:32]);
      cfg.sin_v = $signed(rot_ff[31:0]);
      cfg.k1    = twist_ff[63:32];
      cfg.ky    = twist_ff[31:0];
      cfg.kx    = xflags_ff[31:0];
      cfg.lact  = xflags_ff[32];
      cfg.ract  = xflags_ff[33];
      cfg.kl    = lcurve_ff[63:32];
      cfg.xl    = $signed(lcurve_ff[31:0]);
      cfg.hl    = $signed(ledge_ff[63:32]);
      cfg.xcl   = $signed(ledge_ff[31:0]);
      cfg.kr    = rcurve_ff[63:32];
      cfg.xr    = $signed(rcurve_ff[31:0]);
      cfg.hr    = $signed(redge_ff[63:32]);
      cfg.xcr   = $signed(redge_ff[31:0]);
   end

   // ---------------- input skid and pipeline control ----------------
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = !skid_full_ff;
   assign fire_in    = req_tvalid && req_tready;
   assign s_data     = skid_full_ff ? skid_data_ff : req_tdata;

   assign skid_full_in = adv ? 1'b0 : (skid_full_ff || fire_in);
   assign skid_data_in = (fire_in && !adv) ? req_tdata : skid_data_ff;

   always_comb begin
      vld_in[0] = skid_full_ff || fire_in;
      for (int i = 1; i < 7; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
         out_vld_ff   <= 1'b0;
         for (int i = 0; i < 7; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         skid_full_ff <= skid_full_in;
         if (adv) begin
            out_vld_ff <= out_vld_in;
            for (int i = 0; i < 7; i++) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      skid_data_ff <= skid_data_in;
   end

   // ---------------- datapath ----------------
   kbe_front u_front (
      .clock (clock),
      .adv   (adv),
      .t0    (s_data[31:0]),
      .t1    (s_data[63:32]),
      .t2    (s_data[95:64]),
      .cfg   (cfg),
      .fr    (fr)
   );

   kbe_quad u_quad_t0 (
      .clock (clock),
      .adv   (adv),
      .m     (fr.m0),
      .k     (cfg.k1),
      .q     (q0)
   );

   kbe_quad u_quad_y (
      .clock (clock),
      .adv   (adv),
      .m     (fr.my),
      .k     (cfg.ky),
      .q     (qy)
   );

   kbe_quad u_quad_x (
      .clock (clock),
      .adv   (adv),
      .m     (fr.mx),
      .k     (fr.kxsel),
      .q     (qx)
   );

   kbe_swap u_swap_left (
      .clock   (clock),
      .adv     (adv),
      .xn      (fr.xnl),
      .y       (fr.y),
      .cos_v   (cfg.cos_v),
      .sin_v   (cfg.sin_v),
      .new_one (swp_w.l1),
      .new_two (swp_w.l2)
   );

   kbe_swap u_swap_right (
      .clock   (clock),
      .adv     (adv),
      .xn      (fr.xnr),
      .y       (fr.y),
      .cos_v   (cfg.cos_v),
      .sin_v   (cfg.sin_v),
      .new_one (swp_w.r1),
      .new_two (swp_w.r2)
   );

   // side fields follow the four squaring stages, swap results catch up
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0].off   <= fr.off;
         side_ff[0].ks    <= fr.ks;
         side_ff[0].lmove <= fr.lmove;
         side_ff[0].rmove <= fr.rmove;
         side_ff[0].t1    <= fr.t1;
         side_ff[0].t2    <= fr.t2;
         for (int i = 1; i < 4; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         swp_ff[0] <= swp_w;
         swp_ff[1] <= swp_ff[0];
      end
   end

   assign offs = {{16{side_ff[3].off[31]}}, side_ff[3].off, 16'd0};
   assign e_in = q0 + qy + qx + offs;
   assign ln1  = side_ff[3].lmove ? swp_ff[1].l1 : side_ff[3].t1;
   assign ln2  = side_ff[3].lmove ? swp_ff[1].l2 : side_ff[3].t2;
   assign rn1  = side_ff[3].rmove ? swp_ff[1].r1 : side_ff[3].t1;
   assign rn2  = side_ff[3].rmove ? swp_ff[1].r2 : side_ff[3].t2;

   assign out_vld_in  = vld_ff[6];
   assign out_data_in = {4'd0, rn2, rn1, side_ff[3].rmove, ln2, ln1,
                         side_ff[3].lmove, side_ff[3].ks, e_in};

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTH
   // a held item in the skid drains as soon as the pipeline moves
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_full_ff && adv) |=> !skid_full_ff)
      else $error("skid register did not drain on advance");

   // both swaps only when no kink region holds
   a_both_moved_unkinked: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[66] && rsp_tdata[131]) |->
      (rsp_tdata[65:64] == KINK_NONE))
      else $error("both swaps moved while kinked");

   // left kink forbids the right swap
   a_left_blocks_right: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[65:64] == KINK_LEFT)) |-> !rsp_tdata[131])
      else $error("right swap moved inside left kink");

   // right kink forbids the left swap
   a_right_blocks_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[65:64] == KINK_RIGHT)) |-> !rsp_tdata[66])
      else $error("left swap moved inside right kink");
`endif

endmodule

// ----- bench/kinked_bend_energy_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kinked_bend_energy_test
// Self-checking bench for the kinked bend energy stream. A directed table
// walks reset, extreme and kink-region cases across a few register presets.
// Random phases with fresh register settings follow. Every result item is
// compared field by field with the expected energy, kink state and left and
// right swap proposals, from the table or a local fixed-point prediction.
// ----------------------------------------------------------------------------
module kinked_bend_energy_test;
   import kbe_pkg::*;

   typedef struct packed {
      logic [63:0] energy;
      logic [1:0]  kink;
      logic        left_moved;
      logic [31:0] left_one;
      logic [31:0] left_two;
      logic        right_moved;
      logic [31:0] right_one;
      logic [31:0] right_two;
   } bend_outcome_type;

   typedef struct packed {
      logic [2:0]  setting;
      logic [31:0] angle_zero;
      logic [31:0] angle_one;
      logic [31:0] angle_two;
      logic        typed;
      logic [63:0] energy;
      logic [1:0]  kink;
   } directed_row_type;

   typedef logic [0:6][63:0] reg_set_type;

   localparam int N_DIRECTED   = 23;
   localparam int N_RANDOM     = 550;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 80;
   localparam logic [31:0] Q30_ONE = 32'h4000_0000;
   localparam logic [31:0] COS45   = 32'h2D41_3CCD;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   // angle_zero[31:0], angle_one[63:32], angle_two[95:64]
   logic [IN_W-1:0]     req_tdata   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   // energy[63:0], kink_state[65:64], left_moved[66], left_new_one[98:67],
   // left_new_two[130:99], right_moved[131], right_new_one[163:132],
   // right_new_two[195:164], zero fill[199:196]
   logic [OUT_W-1:0]    rsp_tdata;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [63:0]         csr_pwdata  = '0;
   logic [63:0]         csr_prdata;
   logic                csr_pready;

   bend_outcome_type pending_outcomes[$];
   logic [63:0]   csr_shadow [0:6];
   int            error_count  = 0;
   int            stall_left   = 0;
   bit            hold_pending = 1'b0;
   bit            rx_gaps      = 1'b1;

   kinked_bend_energy dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin : watchdog
      #5_000_000;
      $display("kinked_bend_energy_test: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // fixed-point helpers
   // ------------------------------------------------------------------------
   // floor((p*a + q*b) / 2^30), exact
   function automatic logic signed [63:0] rotate_floor(input logic signed [63:0] p, q, a, b);
      logic signed [127:0] acc;
      acc = p * a + q * b;
      acc = acc >>> 30;
      return acc[63:0];
   endfunction

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return (v < 0) ? -v : v;
   endfunction

   // floor(k * m^2 / 2^40): Q16.16 gain times a Q.28 square, into Q32.32
   function automatic logic [63:0] quad_term(input logic [63:0] m, input logic [31:0] k);
      logic [127:0] p;
      p = m * m * k;
      return p[103:40];
   endfunction

   function automatic logic [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic bend_outcome_type predict_bend_outcome(input logic [31:0] a0, a1, a2);
      bend_outcome_type o;
      logic signed [63:0] t0, t1, t2, c, s, xl, xr, hl, hr, xcl, xcr, x, y, xn, off;
      logic [31:0] k1, ky, kx, kl, kr;
      logic lact, ract, in_left, in_right;
      logic [63:0] sum;
      t0   = $signed(a0);
      t1   = $signed(a1);
      t2   = $signed(a2);
      c    = $signed(csr_shadow[REG_ROT][63:32]);
      s    = $signed(csr_shadow[REG_ROT][31:0]);
      k1   = csr_shadow[REG_TWIST][63:32];
      ky   = csr_shadow[REG_TWIST][31:0];
      kx   = csr_shadow[REG_XFLAGS][31:0];
      lact = csr_shadow[REG_XFLAGS][32];
      ract = csr_shadow[REG_XFLAGS][33];
      kl   = csr_shadow[REG_LCURVE][63:32];
      xl   = $signed(csr_shadow[REG_LCURVE][31:0]);
      hl   = $signed(csr_shadow[REG_LEDGE][63:32]);
      xcl  = $signed(csr_shadow[REG_LEDGE][31:0]);
      kr   = csr_shadow[REG_RCURVE][63:32];
      xr   = $signed(csr_shadow[REG_RCURVE][31:0]);
      hr   = $signed(csr_shadow[REG_REDGE][63:32]);
      xcr  = $signed(csr_shadow[REG_REDGE][31:0]);

      x = rotate_floor(c, -s, t1, t2);
      y = rotate_floor(s, c, t1, t2);
      in_left  = lact && (x < xcl);
      in_right = ract && (x > xcr);

      sum = quad_term(magnitude(t0), k1) + quad_term(magnitude(y), ky);
      off = '0;
      // left branch wins when both regions hold, while the state says right
      if (in_left) begin
         sum += quad_term(magnitude(x - xl), kl);
         off = hl * 64'sd65536;
      end else if (in_right) begin
         sum += quad_term(magnitude(x - xr), kr);
         off = hr * 64'sd65536;
      end else begin
         sum += quad_term(magnitude(x), kx);
      end
      o.energy = sum + off;
      o.kink   = in_right ? KINK_RIGHT : (in_left ? KINK_LEFT : KINK_NONE);

      o.left_moved = lact && !in_right;
      if (o.left_moved) begin
         xn = in_left ? x - xcl : x + xcl;
         o.left_one = clamp32(rotate_floor(c, s, xn, y));
         o.left_two = clamp32(rotate_floor(-s, c, xn, y));
      end else begin
         o.left_one = a1;
         o.left_two = a2;
      end

      o.right_moved = ract && !in_left;
      if (o.right_moved) begin
         xn = in_right ? x - xcr : x + xcr;
         o.right_one = clamp32(rotate_floor(c, s, xn, y));
         o.right_two = clamp32(rotate_floor(-s, c, xn, y));
      end else begin
         o.right_one = a1;
         o.right_two = a2;
      end
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus sources
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] extreme_word();
      case ($urandom_range(0, 4))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic logic [31:0] random_angle();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3: return extreme_word();
         // within about +-4 rad
         default: return $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
      endcase
   endfunction

   function automatic logic [31:0] random_gain();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return extreme_word();
         default: return $urandom_range(0, 32'h0002_0000);
      endcase
   endfunction

   function automatic reg_set_type random_regs();
      reg_set_type r;
      logic [31:0] cs, sn;
      case ($urandom_range(0, 5))
         0: begin cs = Q30_ONE;       sn = 32'h0;   end
         1: begin cs = 32'h0;         sn = Q30_ONE; end
         2: begin cs = 32'hC000_0000; sn = 32'h0;   end
         3: begin cs = COS45;         sn = COS45;   end
         4: begin cs = $urandom;      sn = $urandom; end
         default: begin cs = extreme_word(); sn = extreme_word(); end
      endcase
      r[REG_ROT]    = {cs, sn};
      r[REG_TWIST]  = {random_gain(), random_gain()};
      // upper junk above the two flag bits must be dropped
      r[REG_XFLAGS] = {32'($urandom), random_gain()};
      r[REG_LCURVE] = {random_gain(), random_angle()};
      r[REG_LEDGE]  = {32'($urandom), random_angle()};
      r[REG_RCURVE] = {random_gain(), random_angle()};
      r[REG_REDGE]  = {32'($urandom), random_angle()};
      return r;
   endfunction

   function automatic reg_set_type preset_regs(input int set);
      reg_set_type r;
      case (set)
         // both kinks, crossover at zero, max gains save kl, extreme offsets
         1: r = {{Q30_ONE, 32'h0}, 64'hFFFF_FFFF_FFFF_FFFF, 64'h3_FFFF_FFFF,
                 64'h0001_0000_F000_0000, 64'h8000_0000_0000_0000,
                 64'hFFFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_0000_0000};
         // left crossover above right one: overlapping regions
         2: r = {{Q30_ONE, 32'h0}, 64'h0001_0000_0000_8000, 64'h3_0002_0000,
                 64'h0003_0000_1000_0000, 64'h0005_0000_1000_0000,
                 64'h0000_4000_E000_0000, 64'hFFFB_0000_F000_0000};
         // rotation at -2.0, left only with junk flag bits, extreme edges
         3: r = {64'h8000_0000_8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFD_FFFF_FFFF,
                 64'hFFFF_FFFF_8000_0000, 64'h7FFF_FFFF_7FFF_FFFF,
                 64'hFFFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000};
         // 45 degree kink, right only
         default: r = {{COS45, COS45}, 64'h0000_8000_0001_0000, 64'h2_0000_8000,
                       64'h0, 64'h0, 64'h0002_0000_0800_0000, 64'h0001_8000_F800_0000};
      endcase
      return r;
   endfunction

   function automatic directed_row_type directed_row(input int i);
      directed_row_type r;
      case (i)
         // reset settings: zero energy, no kink, angles pass through
         0:  r = '{3'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 64'd0, KINK_NONE};
         1:  r = '{3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 64'd0, KINK_NONE};
         2:  r = '{3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 64'd0, KINK_NONE};
         3:  r = '{3'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 64'd0, KINK_NONE};
         4:  r = '{3'd0, 32'h1234_5678, 32'hEDCB_A988, 32'h5555_5555, 1'b1, 64'd0, KINK_NONE};
         5:  r = '{3'd1, 32'h8000_0000, 32'hF000_0000, 32'h0000_0000, 1'b0, 64'd0, KINK_NONE};
         6:  r = '{3'd1, 32'h7FFF_FFFF, 32'h1000_0000, 32'h8000_0000, 1'b0, 64'd0, KINK_NONE};
         7:  r = '{3'd1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 64'd0, KINK_NONE};
         8:  r = '{3'd1, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 64'd0, KINK_NONE};
         9:  r = '{3'd1, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 64'd0, KINK_NONE};
         10: r = '{3'd1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 64'd0, KINK_NONE};
         11: r = '{3'd2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 64'd0, KINK_NONE};
         12: r = '{3'd2, 32'h1000_0000, 32'h2000_0000, 32'h0000_0000, 1'b0, 64'd0, KINK_NONE};
         13: r = '{3'd2, 32'hF000_0000, 32'hE000_0000, 32'h1000_0000, 1'b0, 64'd0, KINK_NONE};
         14: r = '{3'd2, 32'h0000_0000, 32'h1000_0000, 32'h0000_0000, 1'b0, 64'd0, KINK_NONE};
         15: r = '{3'd2, 32'h0000_0000, 32'hF000_0000, 32'h0000_0000, 1'b0, 64'd0, KINK_NONE};
         16: r = '{3'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 64'd0, KINK_NONE};
         17: r = '{3'd3, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 64'd0, KINK_NONE};
         18: r = '{3'd3, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 64'd0, KINK_NONE};
         19: r = '{3'd3, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 64'd0, KINK_NONE};
         20: r = '{3'd4, 32'h1000_0000, 32'h2000_0000, 32'hF000_0000, 1'b0, 64'd0, KINK_NONE};
         21: r = '{3'd4, 32'hF000_0000, 32'hC000_0000, 32'h3000_0000, 1'b0, 64'd0, KINK_NONE};
         default: r = '{3'd4, 32'h0, 32'h0, 32'h0, 1'b0, 64'd0, KINK_NONE};
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // bus tasks
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic csr_access(input bit write, input logic [2:0] idx,
                             input logic [63:0] value, output logic [63:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   task automatic readback_registers();
      logic [63:0] rdata;
      for (int i = 0; i < 7; i++) begin
         csr_access(1'b0, 3'(i), 64'd0, rdata);
         check_field($sformatf("register %0d readback", i), rdata, csr_shadow[i]);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic load_registers(input reg_set_type v);
      logic [63:0] rdata;
      for (int i = 0; i < 7; i++) begin
         csr_access(1'b1, 3'(i), v[i], rdata);
         csr_shadow[i] = (3'(i) == REG_XFLAGS) ? (v[i] & 64'h3_FFFF_FFFF) : v[i];
      end
      readback_registers();
   endtask

   task automatic send_item(input logic [IN_W-1:0] data, input int gap,
                            input bend_outcome_type expected);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      pending_outcomes.insert(pending_outcomes.size(), expected);
   endtask

   // stop offering, wait for every result, then let the pipe settle
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   always begin : result_pacing
      @(negedge clock);
      if (hold_pending) begin
         hold_pending = 1'b0;
         stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      bend_outcome_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.energy      = rsp_tdata[63:0];
         got.kink        = rsp_tdata[65:64];
         got.left_moved  = rsp_tdata[66];
         got.left_one    = rsp_tdata[98:67];
         got.left_two    = rsp_tdata[130:99];
         got.right_moved = rsp_tdata[131];
         got.right_one   = rsp_tdata[163:132];
         got.right_two   = rsp_tdata[195:164];
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result, energy", got.energy, 64'd0);
         end else begin
            want = pending_outcomes.pop_front();
            check_field("energy", got.energy, want.energy);
            check_field("kink_state", 64'(got.kink), 64'(want.kink));
            check_field("left_moved", 64'(got.left_moved), 64'(want.left_moved));
            check_field("left_new_one", 64'(got.left_one), 64'(want.left_one));
            check_field("left_new_two", 64'(got.left_two), 64'(want.left_two));
            check_field("right_moved", 64'(got.right_moved), 64'(want.right_moved));
            check_field("right_new_one", 64'(got.right_one), 64'(want.right_one));
            check_field("right_new_two", 64'(got.right_two), 64'(want.right_two));
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      directed_row_type row;
      bend_outcome_type want;
      logic [31:0]   a0, a1, a2;
      int            active_set, sent, phase, phase_len, gap;
      bit            tx_gaps;

      for (int i = 0; i < 7; i++) csr_shadow[i] = 64'd0;
      csr_shadow[REG_ROT] = ROT_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      readback_registers();

      active_set = 0;
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = directed_row(i);
         if (row.setting != active_set) begin
            drain_results();
            load_registers(preset_regs(row.setting));
            active_set = row.setting;
         end
         if (row.typed)
            want = '{row.energy, row.kink, 1'b0, row.angle_one, row.angle_two,
                     1'b0, row.angle_one, row.angle_two};
         else
            want = predict_bend_outcome(row.angle_zero, row.angle_one, row.angle_two);
         gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
         send_item({row.angle_two, row.angle_one, row.angle_zero}, gap, want);
      end

      sent  = 0;
      phase = 0;
      while (sent < N_RANDOM) begin
         drain_results();
         load_registers(random_regs());
         tx_gaps   = ($urandom_range(0, 2) != 0);
         rx_gaps   = ($urandom_range(0, 2) != 0);
         phase_len = $urandom_range(40, 90);
         for (int n = 0; n < phase_len && sent < N_RANDOM; n++) begin
            // receiver holds off long while items keep coming back to back
            if (phase == 1 && n == 10) hold_pending = 1'b1;
            if (phase == 2 && n == 25) drain_results();
            a0 = random_angle();
            a1 = random_angle();
            a2 = random_angle();
            gap = (tx_gaps && phase != 1) ? pick_gap() : 0;
            send_item({a2, a1, a0}, gap, predict_bend_outcome(a0, a1, a2));
            sent++;
         end
         phase++;
      end

      drain_results();
      if (error_count == 0) begin
         $display("kinked_bend_energy_test: done, clean");
      end else begin
         $display("kinked_bend_energy_test: done, errors");
      end
      $finish;
   end

endmodule
